[design/ipp_pkg.sv]
// Shared types, character codes and helper functions for the address text parser.
// Used by ipp_v4_parser, ipp_v6_parser and ip_address_text_parser.
`default_nettype none

package ipp_pkg;

    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_F   = 8'h66;

    localparam logic [31:0] V4_PART_MAX = 32'h0000_00FF;
    localparam int          NUM_GROUPS  = 8;
    localparam logic [3:0]  NO_EXPAND   = 4'd8;
    localparam logic [3:0]  IDX_MAX     = 4'd15;
    localparam logic [2:0]  MAX_HEX_DIG = 3'd4;
    localparam logic [2:0]  DCNT_MAX    = 3'd7;

    localparam logic FAM_IPV4 = 1'b0;
    localparam logic FAM_IPV6 = 1'b1;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // one step of work handed to both parsers
    typedef struct packed {
        logic       take;    // a character is consumed
        logic       finish;  // end of string consumed: return to reset state
        logic [7:0] ch;
    } t_step;

    typedef struct packed {
        logic        err;
        logic [31:0] addr;   // zero when err
        logic [15:0] port;   // zero when err
    } t_v4_result;

    typedef struct packed {
        logic        err;
        logic [63:0] hi;     // zero when err
        logic [63:0] lo;
        logic [15:0] port;
    } t_v6_result;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [3:0] dec_value(input logic [7:0] c);
        logic [7:0] d;
        d = c - CH_ZERO;
        return d[3:0];
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
            d = c - CH_ZERO;
            return {1'b1, d[3:0]};
        end else if ((c >= CH_UP_A) && (c <= CH_UP_F)) begin
            d = c - CH_UP_A + 8'd10;
            return {1'b1, d[3:0]};
        end else if ((c >= CH_LO_A) && (c <= CH_LO_F)) begin
            d = c - CH_LO_A + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

`default_nettype wire

[design/ipp_v4_parser.sv]
// Dotted decimal parser with optional port; holds its own state registers.
// Depends on ipp_pkg.
`default_nettype none

module ipp_v4_parser
    import ipp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_step      i_step,
    output t_v4_result      o_result
);

    logic [31:0] r_number,    n_number;
    logic        r_seen,      n_seen;
    logic [31:0] r_addr,      n_addr;
    logic [2:0]  r_dots,      n_dots;
    logic        r_has_port,  n_has_port;
    logic        r_err,       n_err;

    logic        close_bad;
    logic [31:0] num_x10;

    assign close_bad = !r_seen || (r_number > V4_PART_MAX) || (r_dots > 3'd3) || r_has_port;
    assign num_x10   = (r_number << 3) + (r_number << 1);

    always_comb begin
        n_number   = r_number;
        n_seen     = r_seen;
        n_addr     = r_addr;
        n_dots     = r_dots;
        n_has_port = r_has_port;
        n_err      = r_err;
        if (i_step.finish) begin
            n_number   = '0;
            n_seen     = 1'b0;
            n_addr     = '0;
            n_dots     = '0;
            n_has_port = 1'b0;
            n_err      = 1'b0;
        end else if (i_step.take && !r_err) begin
            if (is_dec(i_step.ch)) begin
                n_number = num_x10 + {28'd0, dec_value(i_step.ch)};
                n_seen   = 1'b1;
            end else if ((i_step.ch == CH_DOT) || (i_step.ch == CH_COLON)) begin
                if (close_bad) begin
                    n_err = 1'b1;
                end else begin
                    n_addr   = {r_addr[23:0], r_number[7:0]};
                    n_seen   = 1'b0;
                    n_number = '0;
                    if (i_step.ch == CH_DOT) begin
                        n_dots = r_dots + 3'd1;
                    end else begin
                        n_has_port = 1'b1;
                    end
                end
            end else begin
                n_err = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number   <= '0;
            r_seen     <= 1'b0;
            r_addr     <= '0;
            r_dots     <= '0;
            r_has_port <= 1'b0;
            r_err      <= 1'b0;
        end else begin
            r_number   <= n_number;
            r_seen     <= n_seen;
            r_addr     <= n_addr;
            r_dots     <= n_dots;
            r_has_port <= n_has_port;
            r_err      <= n_err;
        end
    end

    // end-of-string evaluation on the current state
    always_comb begin
        logic        err;
        logic [31:0] addr;
        logic [15:0] port;
        err  = r_err || !r_seen;
        addr = r_addr;
        port = '0;
        if (!err) begin
            if (r_has_port) begin
                port = r_number[15:0];
            end else if ((r_number > V4_PART_MAX) || (r_dots > 3'd3)) begin
                err = 1'b1;
            end else begin
                addr = {r_addr[23:0], r_number[7:0]};
            end
        end
        o_result.err  = err;
        o_result.addr = err ? 32'd0 : addr;
        o_result.port = err ? 16'd0 : port;
    end

endmodule

`default_nettype wire

[design/ipp_v6_parser.sv]
// Hex group parser with zero expansion and bracketed port; holds its own state.
// Depends on ipp_pkg.
`default_nettype none

module ipp_v6_parser
    import ipp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_step      i_step,
    output t_v6_result      o_result
);

    logic [NUM_GROUPS-1:0][15:0] r_groups, n_groups;
    logic [3:0]  r_idx,     n_idx;
    logic [2:0]  r_dcnt,    n_dcnt;
    logic [3:0]  r_expand,  n_expand;
    logic [15:0] r_port,    n_port;   // the full 16 bits reach the result as the port
    logic        r_bracket, n_bracket;
    logic        r_in_port, n_in_port;
    logic        r_started, n_started;
    logic        r_err,     n_err;

    logic [4:0]  hexv;
    logic        first;
    logic [3:0]  idx_inc;
    logic [15:0] port_x10;

    assign hexv     = hex_value(i_step.ch);
    assign first    = !r_started;
    assign idx_inc  = (r_idx < IDX_MAX) ? r_idx + 4'd1 : r_idx;
    assign port_x10 = (r_port << 3) + (r_port << 1);

    always_comb begin
        n_groups  = r_groups;
        n_idx     = r_idx;
        n_dcnt    = r_dcnt;
        n_expand  = r_expand;
        n_port    = r_port;
        n_bracket = r_bracket;
        n_in_port = r_in_port;
        n_started = r_started;
        n_err     = r_err;
        if (i_step.finish) begin
            n_groups  = '0;
            n_idx     = '0;
            n_dcnt    = '0;
            n_expand  = NO_EXPAND;
            n_port    = '0;
            n_bracket = 1'b0;
            n_in_port = 1'b0;
            n_started = 1'b0;
            n_err     = 1'b0;
        end else if (i_step.take && !r_err) begin
            n_started = 1'b1;
            if (!r_in_port && hexv[4]) begin
                if ((r_idx >= NO_EXPAND) || (r_dcnt >= MAX_HEX_DIG)) begin
                    n_err = 1'b1;
                end else begin
                    n_groups[r_idx[2:0]] = {r_groups[r_idx[2:0]][11:0], hexv[3:0]};
                    n_dcnt = r_dcnt + 3'd1;
                end
            end else if (r_in_port && is_dec(i_step.ch)) begin
                if (r_bracket) begin
                    n_err = 1'b1;
                end else begin
                    n_port = port_x10 + {12'd0, dec_value(i_step.ch)};
                    if (r_dcnt < DCNT_MAX) begin
                        n_dcnt = r_dcnt + 3'd1;
                    end
                end
            end else if (i_step.ch == CH_COLON) begin
                n_dcnt = '0;
                if (r_in_port) begin
                    n_bracket = 1'b0;
                end else if (r_dcnt == 3'd0) begin
                    if (!first) begin
                        if (r_expand < NO_EXPAND) begin
                            n_err  = 1'b1;
                            n_dcnt = r_dcnt;
                        end else begin
                            n_expand = r_idx;
                        end
                    end
                end else begin
                    n_idx = idx_inc;
                end
            end else if (i_step.ch == CH_LBRACK) begin
                if (!first) begin
                    n_err = 1'b1;
                end else begin
                    n_bracket = 1'b1;
                end
            end else if (i_step.ch == CH_RBRACK) begin
                if ((r_dcnt == 3'd0) && (r_expand >= NO_EXPAND)) begin
                    n_err = 1'b1;
                end else begin
                    if (r_dcnt != 3'd0) begin
                        n_idx = idx_inc;
                    end
                    if (!r_bracket) begin
                        n_err = 1'b1;
                    end else begin
                        n_in_port = 1'b1;
                    end
                end
            end else begin
                n_err = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_groups  <= '0;
            r_idx     <= '0;
            r_dcnt    <= '0;
            r_expand  <= NO_EXPAND;
            r_port    <= '0;
            r_bracket <= 1'b0;
            r_in_port <= 1'b0;
            r_started <= 1'b0;
            r_err     <= 1'b0;
        end else begin
            r_groups  <= n_groups;
            r_idx     <= n_idx;
            r_dcnt    <= n_dcnt;
            r_expand  <= n_expand;
            r_port    <= n_port;
            r_bracket <= n_bracket;
            r_in_port <= n_in_port;
            r_started <= n_started;
            r_err     <= n_err;
        end
    end

    // End of string: close the open group, then move the groups after the
    // "::" to the tail of the address (a rotate by the final group index).
    always_comb begin
        logic                        err;
        logic [3:0]                  idx;
        logic [4:0]                  src;
        logic [NUM_GROUPS-1:0][15:0] g;
        err = r_err;
        idx = r_idx;
        src = '0;
        g   = r_groups;
        if (!err) begin
            if (r_dcnt == 3'd0) begin
                if ((r_expand >= NO_EXPAND) || r_in_port) begin
                    err = 1'b1;
                end
            end else if (!r_in_port) begin
                idx = idx_inc;
            end
        end
        if (!err && (idx > NO_EXPAND)) begin
            err = 1'b1;
        end
        if (!err && (idx != NO_EXPAND) && (r_expand >= NO_EXPAND)) begin
            err = 1'b1;
        end
        if (r_expand < NO_EXPAND) begin
            for (int k = 0; k < NUM_GROUPS; k++) begin
                src = 5'(k) + {1'b0, idx};
                if (5'(k) < {1'b0, r_expand}) begin
                    g[k] = r_groups[k];
                end else if (src >= ({1'b0, r_expand} + 5'd8)) begin
                    g[k] = r_groups[src[2:0]];
                end else begin
                    g[k] = '0;
                end
            end
        end
        o_result.err  = err;
        o_result.hi   = err ? 64'd0 : {g[0], g[1], g[2], g[3]};
        o_result.lo   = err ? 64'd0 : {g[4], g[5], g[6], g[7]};
        o_result.port = err ? 16'd0 : r_port;
    end

endmodule

`default_nettype wire

[design/ip_address_text_parser.sv]
// Top level of the IPv4/IPv6 address text parser: input register, both
// parsers, family selection and result register. Depends on ipp_pkg,
// ipp_v4_parser and ipp_v6_parser.
//
//   channel  direction  handshake          payload
//   input    in         i_valid / o_stall  i_kind, i_char_code
//   result   out        o_valid / i_stall  o_status, o_family, o_addr_high,
//                                          o_addr_low, o_port_number
//
// One item per cycle while o_stall is low. An item is held in the input register;
// the parser state updates when it is consumed from there, and an end-of-string item
// writes the result register at that same edge, which raises o_valid.
// Reset (synchronous, i_rst_n low) clears all parser state and both valids.
// Characters keep flowing while a result waits; only an end-of-string item
// waits in the input register while the result register is full and stalled.
`default_nettype none

module ip_address_text_parser
    import ipp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_kind,
    input  wire logic [7:0]  i_char_code,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_status,
    output logic             o_family,
    output logic [63:0]      o_addr_high,
    output logic [63:0]      o_addr_low,
    output logic [15:0]      o_port_number
);

    logic        r_in_valid;
    logic        r_kind;
    logic [7:0]  r_char;
    logic        r_saw_dot, n_saw_dot;
    logic        r_out_valid;
    logic        r_status;
    logic        r_family;
    logic [63:0] r_addr_high;
    logic [63:0] r_addr_low;
    logic [15:0] r_port;

    logic        out_free;
    logic        consume;
    t_step       step;
    t_v4_result  v4_res;
    t_v6_result  v6_res;

    assign out_free = !r_out_valid || !i_stall;
    assign consume  = r_in_valid && ((r_kind == KIND_CHAR) || out_free);
    assign o_stall  = r_in_valid && !consume;

    assign step.take   = consume && (r_kind == KIND_CHAR);
    assign step.finish = consume && (r_kind == KIND_END);
    assign step.ch     = r_char;

    ipp_v4_parser u_v4 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .o_result (v4_res)
    );

    ipp_v6_parser u_v6 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .o_result (v6_res)
    );

    always_comb begin
        n_saw_dot = r_saw_dot;
        if (step.finish) begin
            n_saw_dot = 1'b0;
        end else if (step.take && (r_char == CH_DOT)) begin
            n_saw_dot = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_saw_dot   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_saw_dot <= n_saw_dot;
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (step.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_kind <= i_kind;
            r_char <= i_char_code;
        end
        if (step.finish) begin
            if (r_saw_dot) begin
                r_status    <= v4_res.err;
                r_family    <= FAM_IPV4;
                r_addr_high <= '0;
                r_addr_low  <= {32'd0, v4_res.addr};
                r_port      <= v4_res.port;
            end else begin
                r_status    <= v6_res.err;
                r_family    <= FAM_IPV6;
                r_addr_high <= v6_res.hi;
                r_addr_low  <= v6_res.lo;
                r_port      <= v6_res.port;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_family      = r_family;
    assign o_addr_high   = r_addr_high;
    assign o_addr_low    = r_addr_low;
    assign o_port_number = r_port;

    // characters are never held back by a waiting result
    a_char_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (r_kind == KIND_CHAR)) |-> !o_stall)
        else $error("character item blocked in input register");

    // the dot flag starts over after every end of string
    a_dot_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step.finish |=> !r_saw_dot)
        else $error("dot flag survived end of string");

    // an IPv4 result never carries upper address bits
    a_v4_high_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_family == FAM_IPV4)) |-> (o_addr_high == 64'd0))
        else $error("IPv4 result with nonzero upper address");

    // invalid text reports an all-zero address and port
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |->
            ((o_addr_high == 64'd0) && (o_addr_low == 64'd0) && (o_port_number == 16'd0)))
        else $error("error result with nonzero payload");

endmodule

`default_nettype wire
